// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, disabled while reset is low.
`define PMBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication from one condition to a consequence in the same cycle.
`define PMBR_ASSERT_IMP(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);
`endif

// File: hdl/pmbr_pkg.sv
// Types and constants for the pixel mask, bounding box and ROI placer.
`default_nettype none
package pmbr_pkg;
  localparam int SCORE_W = 16;
  localparam int COORD_W = 20;
  localparam int VAL_W   = 16;
  localparam int TIDX_W  = 5;
  localparam int CFG_W   = 16;
  localparam int CFGI_W  = 3;

  localparam logic [1:0] OP_SCORE = 2'd0;
  localparam logic [1:0] OP_BP    = 2'd1;
  localparam logic [1:0] OP_SCALE = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_HEIGHT    = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_ROIS      = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_INTERVALS = 3'd4;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [SCORE_W-1:0] score;
    logic                     last_channel;
    logic [TIDX_W-1:0]        table_index;
    logic [VAL_W-1:0]         table_value;
  } pmbr_in_t;

  typedef struct packed {
    logic                      kind;
    logic                      mask_bit;
    logic [15:0]               image_index;
    logic signed [COORD_W-1:0] roi_left;
    logic signed [COORD_W-1:0] roi_top;
    logic signed [COORD_W-1:0] roi_right;
    logic signed [COORD_W-1:0] roi_bottom;
    logic                      last;
  } pmbr_out_t;

  typedef struct packed {
    logic              bp_we;
    logic              sc_we;
    logic [TIDX_W-1:0] index;
    logic [VAL_W-1:0]  value;
  } pmbr_tbl_wr_t;
endpackage
`default_nettype wire

// File: hdl/pixel_mask_bbox_roi_placer.sv
// Top level: per-pixel mask, bounding box tracking and square ROI sequencing.
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | pmbr_in_t
//  out_    | output    | out_valid / out_ready | pmbr_out_t
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
// A score or table item is accepted when the control is idle and the result register is free.
// At image end each ROI searches the breakpoints, reads its scale, divides in the serial
// divider, then centres and clamps the square; input is held off meanwhile.
// Reset is synchronous and clears control state; tables hold garbage until loaded.
// A stalled result register holds off new input items.
`default_nettype none
module pixel_mask_bbox_roi_placer #(
  parameter int MAX_DIM = 1024,
  parameter int MAX_ROIS = 4,
  parameter int MAX_INTERVALS = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  pmbr_pkg::pmbr_in_t            in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output pmbr_pkg::pmbr_out_t           out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [pmbr_pkg::CFGI_W-1:0]    cfg_index,
  input  wire [pmbr_pkg::CFG_W-1:0]     cfg_data
);
  import pmbr_pkg::*;

  localparam int BP_DEPTH = MAX_ROIS * MAX_INTERVALS;
  localparam int SC_DEPTH = MAX_ROIS * (MAX_INTERVALS + 1);
  localparam int BP_AW = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
  localparam int SC_AW = $clog2(SC_DEPTH);
  localparam int DIM_W = $clog2(MAX_DIM + 2);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CW    = DIM_W + 10;
  localparam int NUM_W = DIM_W + 8;
  localparam int RW    = $clog2(MAX_ROIS + 1);
  localparam int PW    = $clog2(MAX_INTERVALS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BP   = 4'd1;
  localparam logic [3:0] S_BPC  = 4'd2;
  localparam logic [3:0] S_SC   = 4'd3;
  localparam logic [3:0] S_SCW  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_CEN  = 4'd6;
  localparam logic [3:0] S_FAR  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic signed [SCORE_W-1:0] thr_r;
  logic [10:0] cfg_w_r, cfg_h_r;
  logic [2:0]  cfg_rois_r, cfg_iv_r;

  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic bg_r, bg_nxt, fcp_r, fcp_nxt, found_r, found_nxt;
  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CNT_W-1:0] minx_r, minx_nxt, miny_r, miny_nxt, maxx_r, maxx_nxt, maxy_r, maxy_nxt;
  logic [15:0] img_r, img_nxt;

  logic signed [CW-1:0] x1_r, x1_nxt, y1_r, y1_nxt, rw_r, rw_nxt, rh_r, rh_nxt;
  logic signed [CW-1:0] sq_r, sq_nxt, side_r, side_nxt, l_r, l_nxt, t_r, t_nxt;
  logic signed [CW-1:0] rr_r, rr_nxt, bb_r, bb_nxt;
  logic [DIM_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [RW-1:0] rois_r, rois_nxt, r_r, r_nxt;
  logic [PW-1:0] iv_r, iv_nxt, p_r, p_nxt;
  logic [BP_AW-1:0] bi_r, bi_nxt;
  logic [SC_AW-1:0] si_r, si_nxt, sb_r, sb_nxt;

  logic out_valid_r, out_valid_nxt;
  pmbr_out_t out_r, out_nxt;

  logic in_fire, out_free, div_start, div_done;
  logic [NUM_W-1:0] div_quo;
  logic [VAL_W-1:0] sc_data, den;
  logic [DIM_W-1:0] bp_data, w_cl, h_cl;
  logic signed [CW-1:0] bp_ext, w_s, h_s, ext, rr_t, bb_t;
  logic signed [SCORE_W-1:0] pb;
  logic pbg, mask, end_img;
  logic [CNT_W-1:0] nminx, nminy, nmaxx, nmaxy;
  logic nfound;
  logic signed [CW-1:0] bx1, by1, bx2, by2;
  logic [RW-1:0] rois_cl;
  logic [PW-1:0] iv_cl;
  pmbr_tbl_wr_t tbl_wr;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign tbl_wr.bp_we = in_fire && in_data.operation == OP_BP;
  assign tbl_wr.sc_we = in_fire && in_data.operation == OP_SCALE;
  assign tbl_wr.index = in_data.table_index;
  assign tbl_wr.value = in_data.table_value;

  pmbr_tables #(
    .MAX_DIM(MAX_DIM), .BP_DEPTH(BP_DEPTH), .SC_DEPTH(SC_DEPTH),
    .BP_AW(BP_AW), .SC_AW(SC_AW), .DIM_W(DIM_W)
  ) u_tables (
    .clk(clk), .wr(tbl_wr), .bp_addr(bi_r + BP_AW'(p_r)), .sc_addr(si_r),
    .bp_data(bp_data), .sc_data(sc_data)
  );

  assign den = (sc_data == '0) ? VAL_W'(1) : sc_data;

  pmbr_div #(.NUM_W(NUM_W), .DEN_W(VAL_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num({h_r, 8'h00}), .den(den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    w_cl = (cfg_w_r == '0) ? DIM_W'(1) :
           (int'(cfg_w_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_w_r);
    h_cl = (cfg_h_r == '0) ? DIM_W'(1) :
           (int'(cfg_h_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_h_r);
    rois_cl = (int'(cfg_rois_r) > MAX_ROIS) ? RW'(MAX_ROIS) : RW'(cfg_rois_r);
    iv_cl = (int'(cfg_iv_r) > MAX_INTERVALS) ? PW'(MAX_INTERVALS) : PW'(cfg_iv_r);

    if (fcp_r) begin
      pb = in_data.score;
      pbg = 1'b1;
    end else if (in_data.score >= best_r) begin
      pb = in_data.score;
      pbg = 1'b0;
    end else begin
      pb = best_r;
      pbg = bg_r;
    end
    mask = (pb >= thr_r) && !pbg;
    nminx = (mask && col_r < minx_r) ? col_r : minx_r;
    nminy = (mask && row_r < miny_r) ? row_r : miny_r;
    nmaxx = (mask && col_r > maxx_r) ? col_r : maxx_r;
    nmaxy = (mask && row_r > maxy_r) ? row_r : maxy_r;
    nfound = found_r || mask;
    end_img = (DIM_W'(col_r) >= w_cl - DIM_W'(1)) && (DIM_W'(row_r) >= h_cl - DIM_W'(1));
    w_s = CW'(w_cl);
    h_s = CW'(h_cl);
    if (nfound) begin
      bx1 = CW'(nminx); by1 = CW'(nminy); bx2 = CW'(nmaxx); by2 = CW'(nmaxy);
    end else begin
      bx1 = '0; by1 = '0; bx2 = w_s - CW'(1); by2 = h_s - CW'(1);
    end
    bp_ext = CW'(bp_data);
    ext  = '0;
    rr_t = side_r + l_r - CW'(1);
    bb_t = side_r + t_r - CW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    best_nxt = best_r; bg_nxt = bg_r; fcp_nxt = fcp_r; found_nxt = found_r;
    col_nxt = col_r; row_nxt = row_r;
    minx_nxt = minx_r; miny_nxt = miny_r; maxx_nxt = maxx_r; maxy_nxt = maxy_r;
    img_nxt = img_r;
    x1_nxt = x1_r; y1_nxt = y1_r; rw_nxt = rw_r; rh_nxt = rh_r; sq_nxt = sq_r;
    side_nxt = side_r; l_nxt = l_r; t_nxt = t_r; rr_nxt = rr_r; bb_nxt = bb_r;
    w_nxt = w_r; h_nxt = h_r; rois_nxt = rois_r; r_nxt = r_r; iv_nxt = iv_r;
    p_nxt = p_r; bi_nxt = bi_r; si_nxt = si_r; sb_nxt = sb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    div_start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.operation == OP_SCORE) begin
          best_nxt = pb;
          bg_nxt = pbg;
          fcp_nxt = 1'b0;
          if (in_data.last_channel) begin
            fcp_nxt = 1'b1;
            minx_nxt = nminx; miny_nxt = nminy; maxx_nxt = nmaxx; maxy_nxt = nmaxy;
            found_nxt = nfound;
            if (DIM_W'(col_r) >= w_cl - DIM_W'(1)) begin
              col_nxt = '0;
              row_nxt = (DIM_W'(row_r) >= h_cl - DIM_W'(1)) ? '0 : row_r + CNT_W'(1);
            end else begin
              col_nxt = col_r + CNT_W'(1);
            end
            out_valid_nxt = 1'b1;
            out_nxt = '0;
            out_nxt.mask_bit = mask;
            out_nxt.image_index = img_r;
            out_nxt.last = !end_img || rois_cl == '0;
            if (end_img) begin
              minx_nxt = CNT_W'(MAX_DIM - 1); miny_nxt = CNT_W'(MAX_DIM - 1);
              maxx_nxt = '0; maxy_nxt = '0; found_nxt = 1'b0;
              x1_nxt = bx1; y1_nxt = by1;
              rw_nxt = bx2 - bx1 + CW'(1);
              rh_nxt = by2 - by1 + CW'(1);
              sq_nxt = (bx2 - bx1 > by2 - by1) ? bx2 - bx1 + CW'(1) : by2 - by1 + CW'(1);
              w_nxt = w_cl; h_nxt = h_cl;
              rois_nxt = rois_cl; iv_nxt = iv_cl;
              r_nxt = '0; p_nxt = '0; bi_nxt = '0; si_nxt = '0; sb_nxt = '0;
              if (rois_cl == '0) begin
                img_nxt = img_r + 16'd1;
              end else begin
                state_nxt = S_BP;
              end
            end
          end
        end
      end
      S_BP: begin
        state_nxt = (p_r < iv_r) ? S_BPC : S_SC;
      end
      S_BPC: begin
        if (sq_r >= bp_ext) begin
          si_nxt = si_r + SC_AW'(1);
          p_nxt = p_r + PW'(1);
          state_nxt = S_BP;
        end else begin
          state_nxt = S_SC;
        end
      end
      S_SC: begin
        state_nxt = S_SCW;
      end
      S_SCW: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          side_nxt = CW'(div_quo);
          state_nxt = S_CEN;
        end
      end
      S_CEN: begin
        l_nxt = (rw_r < side_r) ? x1_r - ((side_r - rw_r) >>> 1) : x1_r;
        t_nxt = (rh_r < side_r) ? y1_r - ((side_r - rh_r) >>> 1) : y1_r;
        if (l_nxt < ext) l_nxt = '0;
        if (t_nxt < ext) t_nxt = '0;
        state_nxt = S_FAR;
      end
      S_FAR: begin
        rr_nxt = rr_t;
        bb_nxt = bb_t;
        if (rr_t > $signed(CW'(w_r) - CW'(1))) begin
          rr_nxt = CW'(w_r) - CW'(1);
          l_nxt = CW'(w_r) - side_r;
        end
        if (bb_t > $signed(CW'(h_r) - CW'(1))) begin
          bb_nxt = CW'(h_r) - CW'(1);
          t_nxt = CW'(h_r) - side_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.kind = 1'b1;
          out_nxt.image_index = img_r;
          out_nxt.roi_left = COORD_W'(l_r);
          out_nxt.roi_top = COORD_W'(t_r);
          out_nxt.roi_right = COORD_W'(rr_r);
          out_nxt.roi_bottom = COORD_W'(bb_r);
          out_nxt.last = (r_r + RW'(1)) == rois_r;
          if ((r_r + RW'(1)) == rois_r) begin
            img_nxt = img_r + 16'd1;
            state_nxt = S_IDLE;
          end else begin
            r_nxt = r_r + RW'(1);
            p_nxt = '0;
            bi_nxt = bi_r + BP_AW'(iv_r);
            sb_nxt = sb_r + SC_AW'(iv_r) + SC_AW'(1);
            si_nxt = sb_r + SC_AW'(iv_r) + SC_AW'(1);
            state_nxt = S_BP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_r <= '0;
      cfg_w_r <= 11'd1024;
      cfg_h_r <= 11'd1024;
      cfg_rois_r <= 3'd1;
      cfg_iv_r <= 3'd0;
      best_r <= '0;
      bg_r <= 1'b1;
      fcp_r <= 1'b1;
      found_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      minx_r <= CNT_W'(MAX_DIM - 1);
      miny_r <= CNT_W'(MAX_DIM - 1);
      maxx_r <= '0;
      maxy_r <= '0;
      img_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r <= cfg_data;
          CFG_WIDTH:     cfg_w_r <= cfg_data[10:0];
          CFG_HEIGHT:    cfg_h_r <= cfg_data[10:0];
          CFG_ROIS:      cfg_rois_r <= cfg_data[2:0];
          CFG_INTERVALS: cfg_iv_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      best_r <= best_nxt;
      bg_r <= bg_nxt;
      fcp_r <= fcp_nxt;
      found_r <= found_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      minx_r <= minx_nxt;
      miny_r <= miny_nxt;
      maxx_r <= maxx_nxt;
      maxy_r <= maxy_nxt;
      img_r <= img_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x1_r <= x1_nxt; y1_r <= y1_nxt; rw_r <= rw_nxt; rh_r <= rh_nxt; sq_r <= sq_nxt;
    side_r <= side_nxt; l_r <= l_nxt; t_r <= t_nxt; rr_r <= rr_nxt; bb_r <= bb_nxt;
    w_r <= w_nxt; h_r <= h_nxt; rois_r <= rois_nxt; r_r <= r_nxt; iv_r <= iv_nxt;
    p_r <= p_nxt; bi_r <= bi_nxt; si_r <= si_nxt; sb_r <= sb_nxt;
    out_r <= out_nxt;
  end
endmodule
`default_nettype wire

// File: hdl/pmbr_tables.sv
// Breakpoint and scale memories with registered read ports.
`default_nettype none
module pmbr_tables #(
  parameter int MAX_DIM = 1024,
  parameter int BP_DEPTH = 16,
  parameter int SC_DEPTH = 20,
  parameter int BP_AW = 4,
  parameter int SC_AW = 5,
  parameter int DIM_W = 11
) (
  input  wire                         clk,
  input  pmbr_pkg::pmbr_tbl_wr_t      wr,
  input  wire [BP_AW-1:0]             bp_addr,
  input  wire [SC_AW-1:0]             sc_addr,
  output logic [DIM_W-1:0]            bp_data,
  output logic [pmbr_pkg::VAL_W-1:0]  sc_data
);
  import pmbr_pkg::*;

  logic [DIM_W-1:0] bp_mem [BP_DEPTH];
  logic [VAL_W-1:0] sc_mem [SC_DEPTH];
  logic [DIM_W-1:0] bp_sat;

  assign bp_sat = (int'(wr.value) > MAX_DIM + 1) ? DIM_W'(MAX_DIM + 1) : DIM_W'(wr.value);

  always_ff @(posedge clk) begin
    if (wr.bp_we && int'(wr.index) < BP_DEPTH) begin
      bp_mem[BP_AW'(wr.index)] <= bp_sat;
    end
    if (wr.sc_we && int'(wr.index) < SC_DEPTH) begin
      sc_mem[SC_AW'(wr.index)] <= wr.value;
    end
    bp_data <= bp_mem[bp_addr];
    sc_data <= sc_mem[sc_addr];
  end
endmodule
`default_nettype wire

// File: hdl/pmbr_div.sv
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module pmbr_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire [NUM_W-1:0]  num,
  input  wire [DEN_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   sh;
  logic [DEN_W+1:0] diff;

  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign diff = {1'b0, sh} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = diff[DEN_W+1] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ~diff[DEN_W+1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// File: hdl/pmbr_checker.sv
// Port-level checker for the ROI placer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pmbr_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input pmbr_pkg::pmbr_out_t  out_data
);
  `PMBR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `PMBR_ASSERT_IMP(a_roi_busy, out_valid && out_data.kind && !out_data.last, !in_ready, "input taken during ROI run")
  `PMBR_ASSERT_IMP(a_roi_nomask, out_valid && out_data.kind, !out_data.mask_bit, "ROI result carries a mask bit")
  `PMBR_ASSERT_IMP(a_mask_zero, out_valid && !out_data.kind, out_data.roi_left == 0 && out_data.roi_top == 0 && out_data.roi_right == 0 && out_data.roi_bottom == 0, "mask result has coordinates")
endmodule

bind pixel_mask_bbox_roi_placer pmbr_checker u_pmbr_checker (.*);
`default_nettype wire
